/* hw/rtl/bpa_pkg.sv */
package bpa_pkg;
  localparam int Depth      = 10;
  localparam int MaxOrder   = 9;
  localparam int PageBits   = 12;
  localparam int EffOrder   = (MaxOrder < Depth) ? MaxOrder : Depth;
  localparam int BaseLevel  = Depth - EffOrder;
  localparam int NodeBits   = Depth + 1;
  localparam int NodeCount  = 1 << NodeBits;
  localparam int PageCount  = 1 << Depth;
  localparam int LvlBits    = $clog2(Depth + 1);
  localparam int AddrW      = 48;
  localparam int BaseW      = 47;
  localparam int SizeW      = 32;

  localparam logic [2:0] StOcc   = 3'd1;
  localparam logic [2:0] StLeft  = 3'd2;
  localparam logic [2:0] StRight = 3'd4;
  localparam logic [2:0] StBusy  = 3'd7;

  localparam logic [1:0] StsDone   = 2'd0;
  localparam logic [1:0] StsFail   = 2'd1;
  localparam logic [1:0] StsIgnore = 2'd2;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;
endpackage

/* hw/rtl/buddy_page_allocator_top.sv */
// Channel | Dir | Ports
// in      | in  | in_valid, in_stall, in_action, in_request_size, in_free_address
// out     | out | out_valid, out_stall, out_status, out_block_address
// cfg     | in  | cfg_we, cfg_data
// After reset a clearing pass sweeps both memories; no beat is taken then.
// A beat is worked through the node-status memory: one access a cycle, data registered for the next cycle.
// Alloc: read and check each scanned node and ancestor, mark the node, update each ancestor.
// Free: read the owner, clear the node, update each level merged; an ignored free stops short.
// A result waits in the output register while the next beat is taken; a finished beat
// holds in the last state until that register is free.
module buddy_page_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_request_size,
  input  logic [47:0] in_free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [47:0] out_block_address,
  input  logic        cfg_we,
  input  logic [46:0] cfg_data
);
  localparam int NB = bpa_pkg::NodeBits;
  localparam int D  = bpa_pkg::Depth;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_AORD, S_SRD, S_SCHK, S_ARD, S_ACHK, S_MARK, S_MRD, S_MWR,
    S_OWN, S_FRD, S_FCHK, S_FNRD, S_FNCHK, S_FUPRD, S_FUPWR, S_DONE
  } state_t;

  state_t          st_r;
  logic [46:0]     base_r;
  logic [31:0]     size_r;
  logic [47:0]     faddr_r;
  logic [NB:0]     i_r;      // scan index, one spare bit for the end
  logic [NB-1:0]   node_r, cur_r, child_r;
  logic [bpa_pkg::LvlBits-1:0] level_r, lvl_r;
  logic [NB-1:0]   clr_r;
  logic            ov_r;
  logic [1:0]      sts_r;
  logic [47:0]     baddr_r;
  logic [1:0]      osts_r;
  logic [47:0]     obaddr_r;
  logic [D-1:0]    page_r;

  logic            nwe, pwe;
  logic [NB-1:0]   nwa, nra;
  logic [2:0]      nwd, nrd;
  logic [D-1:0]    pwa, pra;
  logic [NB-1:0]   pwd, prd;

  bpa_ram #(.AW(NB), .DW(3)) u_node (
    .clk(clk), .we(nwe), .waddr(nwa), .wdata(nwd), .raddr(nra), .rdata(nrd));
  bpa_ram #(.AW(D), .DW(NB)) u_owner (
    .clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));

  // order from size: smallest o with size <= 2^(o+PageBits)
  logic [bpa_pkg::LvlBits-1:0] ord;
  logic                        fits;
  always_comb begin
    ord  = '0;
    fits = 1'b0;
    for (int o = bpa_pkg::EffOrder; o >= 0; o--) begin
      if ({32'd0, size_r} <= (64'd1 << (o + bpa_pkg::PageBits))) begin
        ord  = bpa_pkg::LvlBits'(o);
        fits = 1'b1;
      end
    end
  end

  // tree level of the node being freed
  logic [bpa_pkg::LvlBits-1:0] node_lvl;
  always_comb begin
    node_lvl = '0;
    for (int b = 1; b < NB; b++) if (node_r[b]) node_lvl = bpa_pkg::LvlBits'(b);
  end

  logic [48:0] limit;
  logic [47:0] off;
  assign limit = {2'b0, base_r} + (49'd1 << (D + bpa_pkg::PageBits));
  assign off   = faddr_r - {1'b0, base_r};

  logic [NB:0]   blk_ext;
  assign blk_ext  = ({1'b0, cur_r} + 1'b1) << (level_r - lvl_r);

  logic [NB-1:0] first_node;
  assign first_node = NB'(node_r << (D - level_r));

  logic done_go;
  assign done_go = (st_r == S_DONE) && (!ov_r || !out_stall);

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = osts_r;
  assign out_block_address = obaddr_r;

  always_comb begin
    nwe = 1'b0; nwa = cur_r; nwd = '0; nra = cur_r;
    pwe = 1'b0; pwa = page_r; pwd = node_r; pra = page_r;
    case (st_r)
      S_CLR: begin
        nwe = 1'b1; nwa = clr_r; nwd = '0;
        pwe = 1'b1; pwa = clr_r[D-1:0]; pwd = '0;
      end
      S_SRD:  nra = i_r[NB-1:0];
      S_MARK: begin nwe = 1'b1; nwa = node_r; nwd = bpa_pkg::StBusy; end
      S_MWR: begin
        nwe = 1'b1; nwa = cur_r;
        nwd = nrd | (child_r[0] ? bpa_pkg::StRight : bpa_pkg::StLeft);
      end
      S_OWN: begin pwe = 1'b1; pwa = page_r; pwd = node_r; end
      S_FNRD: nra = prd;
      S_FNCHK: begin nwe = (nrd[0] && node_r != '0); nwa = node_r; nwd = '0; end
      S_FUPWR: begin
        nwe = 1'b1; nwa = cur_r;
        nwd = nrd & ~(child_r[0] ? bpa_pkg::StRight : bpa_pkg::StLeft);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; ov_r <= 1'b0; base_r <= '0;
    end else begin
      if (cfg_we) base_r <= cfg_data;
      // load the output register as the old beat leaves, else drop it once taken
      if (done_go) begin
        ov_r <= 1'b1; osts_r <= sts_r; obaddr_r <= baddr_r;
      end else if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) st_r <= S_IDLE;
        end
        S_IDLE: if (in_valid && !in_stall) begin
          size_r <= in_request_size; faddr_r <= in_free_address;
          st_r <= (in_action == bpa_pkg::ActAlloc) ? S_AORD : S_FRD;
        end
        S_AORD: begin
          if (!fits) begin
            sts_r <= bpa_pkg::StsFail; baddr_r <= '0; st_r <= S_DONE;
          end else begin
            level_r <= bpa_pkg::LvlBits'(D) - ord;
            i_r <= (NB+1)'(1) << (bpa_pkg::LvlBits'(D) - ord);
            st_r <= S_SRD;
          end
        end
        S_SRD: begin
          if (i_r >= ((NB+1)'(2) << level_r)) begin
            sts_r <= bpa_pkg::StsFail; baddr_r <= '0; st_r <= S_DONE;
          end else st_r <= S_SCHK;
        end
        S_SCHK: begin
          if (nrd != '0) begin
            i_r <= i_r + 1'b1; st_r <= S_SRD;
          end else begin
            node_r <= i_r[NB-1:0]; cur_r <= i_r[NB-1:0]; lvl_r <= level_r;
            st_r <= (level_r > bpa_pkg::BaseLevel) ? S_ARD : S_MARK;
            if (level_r > bpa_pkg::BaseLevel) begin
              cur_r <= i_r[NB-1:1]; lvl_r <= level_r - 1'b1;
            end
          end
        end
        S_ARD: st_r <= S_ACHK;
        S_ACHK: begin
          if (nrd[0]) begin
            i_r <= blk_ext; st_r <= S_SRD;
          end else if (lvl_r > bpa_pkg::BaseLevel) begin
            cur_r <= cur_r >> 1; lvl_r <= lvl_r - 1'b1; st_r <= S_ARD;
          end else st_r <= S_MARK;
        end
        S_MARK: begin
          child_r <= node_r; cur_r <= node_r >> 1; lvl_r <= level_r;
          page_r <= first_node[D-1:0];
          st_r <= (level_r > bpa_pkg::BaseLevel) ? S_MRD : S_OWN;
        end
        S_MRD: st_r <= S_MWR;
        S_MWR: begin
          child_r <= cur_r; cur_r <= cur_r >> 1; lvl_r <= lvl_r - 1'b1;
          st_r <= (lvl_r - 1'b1 > bpa_pkg::BaseLevel) ? S_MRD : S_OWN;
        end
        S_OWN: begin
          sts_r <= bpa_pkg::StsDone;
          baddr_r <= {1'b0, base_r} + (48'(page_r) << bpa_pkg::PageBits);
          st_r <= S_DONE;
        end
        S_FRD: begin
          baddr_r <= '0;
          if ({1'b0, faddr_r} >= limit || faddr_r < {1'b0, base_r}) begin
            sts_r <= bpa_pkg::StsIgnore; st_r <= S_DONE;
          end else begin
            page_r <= off[bpa_pkg::PageBits +: D]; st_r <= S_FCHK;
          end
        end
        S_FCHK: st_r <= S_FNRD;
        S_FNRD: begin node_r <= prd; st_r <= S_FNCHK; end
        S_FNCHK: begin
          if (node_r == '0 || !nrd[0]) begin
            sts_r <= bpa_pkg::StsIgnore; st_r <= S_DONE;
          end else begin
            sts_r <= bpa_pkg::StsDone;
            child_r <= node_r; cur_r <= node_r >> 1;
            lvl_r <= node_lvl;
            st_r <= S_FUPRD;
          end
        end
        S_FUPRD: st_r <= (lvl_r > bpa_pkg::BaseLevel) ? S_FUPWR : S_DONE;
        S_FUPWR: begin
          // stop merging once the buddy is still in use
          if ((nwd & (child_r[0] ? bpa_pkg::StLeft : bpa_pkg::StRight)) != '0)
            st_r <= S_DONE;
          else begin
            child_r <= cur_r; cur_r <= cur_r >> 1; lvl_r <= lvl_r - 1'b1;
            st_r <= S_FUPRD;
          end
        end
        S_DONE: if (done_go) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/bpa_ram.sv */
module bpa_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/bpa_checker.sv */
module bpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [47:0] out_block_address
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)) else $error("hold");
  a_sts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= bpa_pkg::StsIgnore) else $error("status");
  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bpa_pkg::StsDone |-> out_block_address == 48'd0)
    else $error("addr");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("busy");
endmodule

bind buddy_page_allocator_top bpa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_block_address(out_block_address));

/* sim/tb_buddy_page_allocator_top.sv */
`timescale 1ns / 1ps

module tb_buddy_page_allocator_top;

  typedef struct packed {
    logic        action;
    logic [31:0] size;
    logic [47:0] addr;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] block;
  } rsp_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [31:0] in_request_size;
  logic [47:0] in_free_address;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [47:0] out_block_address;
  logic        cfg_we;
  logic [46:0] cfg_data;

  buddy_page_allocator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_request_size(in_request_size), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_address(out_block_address),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // shadow of the allocator state
  logic [2:0]     node_st [bpa_pkg::NodeCount];
  int unsigned    page_node [bpa_pkg::PageCount];
  logic [46:0]    base_addr;
  int unsigned    live_pages [$];

  req_beat_t      pending_reqs [$];
  rsp_beat_t      awaited_rsps [$];
  int             mismatches;
  bit             quiet;
  int unsigned    cyc;
  int unsigned    hold_left;
  int unsigned    hold_at;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("tb_buddy_page_allocator_top: FAIL");
    $finish;
  end

  function automatic void alloc_block(input logic [31:0] sz, output logic [1:0] st,
                                      output logic [47:0] blk);
    longint unsigned size;
    int order;
    int lvl;
    int up;
    longint unsigned i;
    longint unsigned e;
    int unsigned node;
    int unsigned cur;
    int unsigned blocker;
    longint unsigned page;
    size = 64'(sz);
    order = -1;
    st = bpa_pkg::StsFail;
    blk = '0;
    for (int o = 0; o <= bpa_pkg::EffOrder; o++)
      if (order < 0 && size <= (64'd1 << (o + bpa_pkg::PageBits))) order = o;
    if (order < 0) return;
    lvl = bpa_pkg::Depth - order;
    i = 64'd1 << lvl;
    e = 64'd2 << lvl;
    while (i < e) begin
      node = 32'(i);
      if (node_st[node] != 0) begin
        i++;
        continue;
      end
      cur = node;
      up = lvl;
      blocker = 0;
      while (up > bpa_pkg::BaseLevel) begin
        cur = cur >> 1;
        up--;
        if (node_st[cur] & bpa_pkg::StOcc) begin
          blocker = cur;
          break;
        end
      end
      if (blocker != 0) begin
        // skip past the allocated ancestor's subtree
        i = (longint'(blocker) + 1) << (lvl - up);
        continue;
      end
      node_st[node] = bpa_pkg::StBusy;
      cur = node;
      up = lvl;
      while (up > bpa_pkg::BaseLevel) begin
        logic [2:0] side;
        side = cur[0] ? bpa_pkg::StRight : bpa_pkg::StLeft;
        cur = cur >> 1;
        up--;
        node_st[cur] = node_st[cur] | side;
      end
      page = ((longint'(node) << (bpa_pkg::Depth - lvl)) - bpa_pkg::PageCount)
             & (bpa_pkg::PageCount - 1);
      page_node[page] = node;
      st = bpa_pkg::StsDone;
      blk = 48'(longint'(base_addr) + (page << bpa_pkg::PageBits));
      live_pages.push_back(32'(page));
      return;
    end
  endfunction

  function automatic void free_block(input logic [47:0] addr, output logic [1:0] st);
    longint unsigned lim;
    longint unsigned page;
    int unsigned node;
    int unsigned cur;
    int unsigned child;
    int lvl;
    int idx [$];
    lim = longint'(base_addr) + (64'd1 << (bpa_pkg::Depth + bpa_pkg::PageBits));
    st = bpa_pkg::StsIgnore;
    if (addr < base_addr || 64'(addr) >= lim) return;
    page = 64'((addr - base_addr) >> bpa_pkg::PageBits) & (bpa_pkg::PageCount - 1);
    node = page_node[page] & (bpa_pkg::NodeCount - 1);
    if (node == 0 || !(node_st[node] & bpa_pkg::StOcc)) return;
    node_st[node] = 0;
    cur = node;
    lvl = $clog2(node + 1) - 1;
    while (lvl > bpa_pkg::BaseLevel) begin
      child = cur;
      cur = cur >> 1;
      lvl--;
      node_st[cur] = node_st[cur] & ~(child[0] ? bpa_pkg::StRight : bpa_pkg::StLeft);
      // buddy still in use: stop merging
      if (node_st[cur] & (child[0] ? bpa_pkg::StLeft : bpa_pkg::StRight)) break;
    end
    st = bpa_pkg::StsDone;
    idx = live_pages.find_first_index(p) with (p == page);
    if (idx.size() > 0) live_pages.delete(idx[0]);
  endfunction

  task automatic queue_alloc(input logic [31:0] sz);
    rsp_beat_t r;
    alloc_block(sz, r.status, r.block);
    pending_reqs.push_back('{bpa_pkg::ActAlloc, sz, 48'({$urandom, $urandom})});
    awaited_rsps.push_back(r);
  endtask

  task automatic queue_free(input logic [47:0] addr);
    rsp_beat_t r;
    r.block = '0;
    free_block(addr, r.status);
    pending_reqs.push_back('{bpa_pkg::ActFree, 32'($urandom), addr});
    awaited_rsps.push_back(r);
  endtask

  function automatic logic [47:0] live_addr(input int k, input logic [11:0] offs);
    return 48'(longint'(base_addr) + (longint'(live_pages[k]) << bpa_pkg::PageBits)
               + offs);
  endfunction

  task automatic drain_and_set_base(input logic [46:0] v);
    while (pending_reqs.size() != 0 || in_valid || awaited_rsps.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_addr = v;
  endtask

  task automatic random_phase(input int n);
    int unsigned r;
    int unsigned o;
    int k;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        o = $urandom_range(bpa_pkg::EffOrder);
        if ($urandom_range(9) == 0)
          queue_alloc($urandom);
        else if (o == 0)
          queue_alloc($urandom_range(4096));
        else
          queue_alloc($urandom_range((1 << (o - 1)) * 4096 + 1, (1 << o) * 4096));
      end else if (r < 85 && live_pages.size() != 0) begin
        k = $urandom_range(live_pages.size() - 1);
        queue_free(live_addr(k, 12'($urandom)));
      end else if (r < 92) begin
        queue_free(48'({$urandom, $urandom}));
      end else begin
        queue_free(48'(longint'(base_addr)
                       + {$urandom_range(bpa_pkg::PageCount - 1), 12'($urandom)}));
      end
    end
  endtask

  initial begin
    foreach (node_st[n]) node_st[n] = '0;
    foreach (page_node[p]) page_node[p] = 0;
    base_addr = '0;
    mismatches = 0;
    quiet = 1'b0;
    hold_at = 4_000;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: sizes, rounding, no room, blocked subtree, bad frees
    queue_alloc(32'd0);
    queue_alloc(32'd1);
    queue_alloc(32'd4096);
    queue_alloc(32'd4097);
    queue_alloc(32'h0020_0000);
    queue_alloc(32'h0020_0001);
    queue_alloc(32'hFFFF_FFFF);
    queue_alloc(32'h0020_0000);
    queue_alloc(32'd12288);
    queue_free(48'h0000_0000_0123);
    queue_free(48'h0000_0000_0123);
    queue_free(48'h0000_0000_1000);
    queue_free(48'h0000_0040_0000);
    queue_free(48'hFFFF_FFFF_FFFF);
    queue_free(48'h0000_0020_0FFF);
    queue_free(48'h0000_0000_2000);
    queue_free(48'h0000_0000_4000);
    queue_free(48'h0000_0000_6000);
    queue_alloc(32'd1);
    random_phase(400);

    drain_and_set_base(47'h7FFF_FFFF_FFFF);
    queue_free(48'h7FFF_FFFF_FFFE);
    queue_alloc(32'd1);
    queue_free(48'h8000_003F_FFFF);
    queue_free(48'h8000_0040_0000);
    quiet = 1'b1;
    random_phase(400);

    drain_and_set_base(47'({$urandom, $urandom}));
    quiet = 1'b0;
    random_phase(400);

    drain_and_set_base(47'({$urandom, 12'h000}));
    random_phase(400);

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (awaited_rsps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("tb_buddy_page_allocator_top: PASS");
    else
      $display("tb_buddy_page_allocator_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cyc       <= 0;
      hold_left <= 0;
    end else begin
      cyc <= cyc + 1;
      if (hold_left != 0)
        hold_left <= hold_left - 1;
      else if (cyc == hold_at)
        hold_left <= 3000;
    end
  end

  // driver
  always @(posedge clk) begin
    req_beat_t b;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_action       <= 1'b0;
      in_request_size <= '0;
      in_free_address <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 33)) begin
        b = pending_reqs.pop_front();
        in_valid        <= 1'b1;
        in_action       <= b.action;
        in_request_size <= b.size;
        in_free_address <= b.addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_beat_t x;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < 33);
      if (out_valid && !out_stall) begin
        if (awaited_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: status %0d block %h", out_status,
                     out_block_address);
        end else begin
          x = awaited_rsps.pop_front();
          if (out_status !== x.status || out_block_address !== x.block) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected status %0d block %h, got status %0d block %h",
                       x.status, x.block, out_status, out_block_address);
          end
        end
      end
    end
  end

endmodule
